[sv/u8sd_pkg.sv]
`default_nettype none

package u8sd_pkg;

  localparam int CpWidth = 21;
  localparam logic [CpWidth-1:0] ReplChar = 21'h00FFFD;

  typedef enum logic [1:0] {
    BYTE_ASCII,
    BYTE_CONT,
    BYTE_LEAD,
    BYTE_BAD
  } byte_kind_e;

  // One accepted byte's results: rep_cnt replacement chars, then an optional tail.
  typedef struct packed {
    logic [1:0]         rep_cnt;
    logic               has_tail;
    logic               tail_rep;
    logic [CpWidth-1:0] tail_cp;
  } u8sd_desc_t;

endpackage

`default_nettype wire

[sv/u8sd_front.sv]
`default_nettype none

module u8sd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          text_byte_i,
  input  wire logic                end_of_text_i,
  output logic                     push_o,
  output u8sd_pkg::u8sd_desc_t     desc_o
);
  import u8sd_pkg::*;

  logic [CpWidth-1:0] partial_q, partial_d;
  logic [1:0]         need_q, need_d;
  logic [1:0]         held_q, held_d;

  byte_kind_e         kind;
  logic [1:0]         lead_need;
  logic [CpWidth-1:0] lead_bits;
  logic               fresh_tail;
  logic               fresh_rep;
  logic [CpWidth-1:0] fresh_cp;
  logic               fresh_open;
  logic [CpWidth-1:0] cont_code;
  u8sd_desc_t         desc;

  always_comb begin
    lead_need = 2'd0;
    lead_bits = '0;
    if (!text_byte_i[7]) begin
      kind = BYTE_ASCII;
    end else if (text_byte_i[7:6] == 2'b10) begin
      kind = BYTE_CONT;
    end else if (text_byte_i[7:5] == 3'b110) begin
      kind      = BYTE_LEAD;
      lead_need = 2'd1;
      lead_bits = {16'd0, text_byte_i[4:0]};
    end else if (text_byte_i[7:4] == 4'b1110) begin
      kind      = BYTE_LEAD;
      lead_need = 2'd2;
      lead_bits = {17'd0, text_byte_i[3:0]};
    end else if (text_byte_i[7:3] == 5'b11110) begin
      kind      = BYTE_LEAD;
      lead_need = 2'd3;
      lead_bits = {18'd0, text_byte_i[2:0]};
    end else begin
      kind = BYTE_BAD;
    end
  end

  always_comb begin
    fresh_tail = 1'b1;
    fresh_rep  = 1'b1;
    fresh_cp   = ReplChar;
    fresh_open = 1'b0;
    unique case (kind)
      BYTE_ASCII: begin
        fresh_rep = 1'b0;
        fresh_cp  = {13'd0, text_byte_i};
      end
      BYTE_LEAD: begin
        if (!end_of_text_i) begin
          fresh_tail = 1'b0;
          fresh_open = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cont_code = {partial_q[CpWidth-7:0], text_byte_i[5:0]};

  always_comb begin
    desc      = '0;
    partial_d = partial_q;
    need_d    = need_q;
    held_d    = held_q;
    if (need_q != 2'd0) begin
      if (kind == BYTE_CONT) begin
        if (need_q == 2'd1) begin
          desc.has_tail = 1'b1;
          desc.tail_cp  = cont_code;
          partial_d     = '0;
          need_d        = 2'd0;
          held_d        = 2'd0;
        end else if (end_of_text_i) begin
          desc.rep_cnt = held_q + 2'd2;
          partial_d    = '0;
          need_d       = 2'd0;
          held_d       = 2'd0;
        end else begin
          partial_d = cont_code;
          need_d    = need_q - 2'd1;
          held_d    = held_q + 2'd1;
        end
      end else begin
        desc.rep_cnt  = held_q + 2'd1;
        desc.has_tail = fresh_tail;
        desc.tail_rep = fresh_rep;
        desc.tail_cp  = fresh_cp;
        partial_d     = fresh_open ? lead_bits : '0;
        need_d        = fresh_open ? lead_need : 2'd0;
        held_d        = 2'd0;
      end
    end else begin
      desc.has_tail = fresh_tail;
      desc.tail_rep = fresh_rep;
      desc.tail_cp  = fresh_cp;
      if (fresh_open) begin
        partial_d = lead_bits;
        need_d    = lead_need;
        held_d    = 2'd0;
      end
    end
    if (end_of_text_i) begin
      partial_d = '0;
      need_d    = 2'd0;
      held_d    = 2'd0;
    end
  end

  assign desc_o = desc;
  assign push_o = accept_i && ((desc.rep_cnt != 2'd0) || desc.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      need_q    <= 2'd0;
      held_q    <= 2'd0;
    end else if (accept_i) begin
      partial_q <= partial_d;
      need_q    <= need_d;
      held_q    <= held_d;
    end
  end

endmodule

`default_nettype wire

[sv/u8sd_queue.sv]
`default_nettype none

module u8sd_queue #(
  parameter int Depth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire u8sd_pkg::u8sd_desc_t wr_desc_i,
  input  wire logic                pop_i,
  output u8sd_pkg::u8sd_desc_t     rd_desc_o,
  output logic                     empty_o,
  output logic                     full_o
);
  import u8sd_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  u8sd_desc_t    mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign empty_o   = (cnt_q == '0);
  assign full_o    = (cnt_q == FullCnt);
  assign do_wr     = push_i && !full_o;
  assign do_rd     = pop_i && !empty_o;
  assign rd_desc_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/u8sd_back.sv]
`default_nettype none

module u8sd_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire u8sd_pkg::u8sd_desc_t head_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output logic [u8sd_pkg::CpWidth-1:0] m_code_point_o,
  output logic                      m_replaced_o,
  output logic                      m_last_o
);
  import u8sd_pkg::*;

  logic [1:0]         idx_q, idx_d;
  logic               valid_q;
  logic [CpWidth-1:0] cp_q;
  logic               rep_q;
  logic               last_q;

  logic               load;
  logic               emit_rep;
  logic               item_last;
  logic [CpWidth-1:0] item_cp;
  logic               item_rep;

  assign load     = !empty_i && (!valid_q || m_ready_i);
  assign emit_rep = idx_q < head_i.rep_cnt;

  always_comb begin
    if (emit_rep) begin
      item_cp   = ReplChar;
      item_rep  = 1'b1;
      item_last = (({1'b0, idx_q} + 3'd1) == {1'b0, head_i.rep_cnt}) && !head_i.has_tail;
    end else begin
      item_cp   = head_i.tail_cp;
      item_rep  = head_i.tail_rep;
      item_last = 1'b1;
    end
    idx_d = item_last ? 2'd0 : idx_q + 2'd1;
  end

  assign pop_o = load && item_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (!valid_q || m_ready_i) begin
        valid_q <= !empty_i;
      end
      if (load) begin
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= item_cp;
      rep_q  <= item_rep;
      last_q <= item_last;
    end
  end

  assign m_valid_o      = valid_q;
  assign m_code_point_o = cp_q;
  assign m_replaced_o   = rep_q;
  assign m_last_o       = last_q;

endmodule

`default_nettype wire

[sv/utf8_stream_decoder_unit.sv]
`default_nettype none

// UTF-8 stream decoder: takes one text byte per cycle (tlast marks the final byte of the
// text) and gives zero to four code points per byte. A byte is taken every cycle while
// the descriptor queue (QueueDepth entries) has room; results leave at one per cycle
// while tready is high, through a registered output stage. With the queue empty and
// the output stage free, a byte's descriptor is written into the queue and its first
// result is then loaded into the output register, which raises tvalid.
// Malformed input yields U+FFFD with tuser set; tlast flags the last result of each byte.
module utf8_stream_decoder_unit #(
  parameter int QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic        s_axis_tlast_i,   // end_of_text
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [20:0] code_point, [23:21] zero
  output logic             m_axis_tuser_o,   // replaced
  output logic             m_axis_tlast_o    // last_of_run
);
  import u8sd_pkg::*;

  logic               accept;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  u8sd_desc_t         wr_desc;
  u8sd_desc_t         head;
  logic [CpWidth-1:0] code_point;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && !q_full;

  u8sd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (s_axis_tdata_i),
    .end_of_text_i (s_axis_tlast_i),
    .push_o        (push),
    .desc_o        (wr_desc)
  );

  u8sd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_desc_i (wr_desc),
    .pop_i     (pop),
    .rd_desc_o (head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  u8sd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .m_code_point_o (code_point),
    .m_replaced_o   (m_axis_tuser_o),
    .m_last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, code_point};

endmodule

`default_nettype wire
